>>> rtl/core/atat_pkg.sv
package atat_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int RES_W = $clog2(MAX_RESULTS + 1);

	localparam logic [15:0] HOLD_RESET = 16'd60;

	localparam logic [1:0] OP_ALERT = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [2:0] ACT_NOTHING = 3'd0;
	localparam logic [2:0] ACT_START = 3'd1;
	localparam logic [2:0] ACT_STOP = 3'd2;
	localparam logic [2:0] ACT_REFRESHED = 3'd3;
	localparam logic [2:0] ACT_DROPPED = 3'd4;
	localparam logic [2:0] ACT_IGNORED = 3'd5;

	localparam logic [7:0] VERSION_MASK = 8'hf0;
	localparam logic [7:0] VERSION_V4 = 8'h40;
	localparam logic [7:0] PREFIX_V4 = 8'd32;
	localparam logic [7:0] PREFIX_V6 = 8'd128;

	typedef struct packed {
		logic [1:0]  opcode;
		logic        no_packet;
		logic [3:0]  version_nibble;
		logic [63:0] source_high;
		logic [63:0] source_low;
		logic [31:0] signature_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  action;
		logic        is_ipv6;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [7:0]  prefix_len;
		logic [31:0] sig_out;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic        family;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [31:0] expiry;
	} entry_t;

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] raddr;
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
	} ram_req_t;

	function automatic rsp_t make_rsp(input logic [2:0] action, input entry_t ent,
			input logic [31:0] sig, input logic last);
		rsp_t r;
		logic addr;
		addr = (action != ACT_NOTHING) && (action != ACT_IGNORED);
		r.action = action;
		r.is_ipv6 = addr ? ent.family : 1'b0;
		r.addr_high = addr ? ent.addr_high : 64'd0;
		r.addr_low = addr ? ent.addr_low : 64'd0;
		r.prefix_len = addr ? (ent.family ? PREFIX_V6 : PREFIX_V4) : 8'd0;
		r.sig_out = (action == ACT_START) ? sig : 32'd0;
		r.last = last;
		return r;
	endfunction

endpackage

>>> rtl/core/atat_entry_ram.sv
module atat_entry_ram (
	input  logic              clk,
	input  atat_pkg::ram_req_t ram,
	output atat_pkg::entry_t  rd_data
);
	import atat_pkg::*;

	entry_t mem_q [TABLE_ENTRIES];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (ram.we) begin
			mem_q[ram.waddr] <= ram.wdata;
		end
		if (ram.re) begin
			rd_data_q <= mem_q[ram.raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/core/atat_ctrl.sv
module atat_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        hold_seconds,
	input  logic               req_valid,
	output logic               req_ready,
	input  atat_pkg::req_t     req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output atat_pkg::rsp_t     rsp,
	output atat_pkg::ram_req_t ram,
	input  atat_pkg::entry_t   ram_rd_data
);
	import atat_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t             state_q;
	logic [1:0]         op_q;
	logic               ignore_q;
	logic               fam_q;
	logic [63:0]        hi_q;
	logic [63:0]        lo_q;
	logic [31:0]        sig_q;
	logic [31:0]        now_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   idx_q;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               match_q;
	logic [IDX_W-1:0]   match_idx_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic               pend_vld_q;
	rsp_t               pend_q;
	logic [RES_W-1:0]   cnt_q;
	logic               rsp_vld_q;
	rsp_t               rsp_q;

	logic               out_free;
	logic               ent_valid;
	logic [31:0]        age;
	logic               is_remove;
	logic               hit;
	logic               same;
	logic               stall;
	logic               issue;
	logic [31:0]        new_expiry;
	entry_t             wr_entry;
	logic               fin_go;
	logic               alert_write;
	logic               push_s1;
	rsp_t               fin_rsp;
	logic               req_fam;

	assign out_free = !rsp_vld_q || rsp_ready;
	assign ent_valid = valid_q[idx_s1];
	assign age = now_q - ram_rd_data.expiry;
	assign is_remove = (op_q == OP_TICK) || (op_q == OP_FLUSH);
	assign hit = vld_s1 && is_remove && ent_valid && ((op_q == OP_FLUSH) || !age[31])
		&& (cnt_q < RES_W'(MAX_RESULTS));
	assign same = ent_valid && (ram_rd_data.family == fam_q)
		&& (ram_rd_data.addr_high == hi_q) && (ram_rd_data.addr_low == lo_q);
	assign stall = hit && pend_vld_q && !out_free;
	assign issue = (state_q == S_SCAN) && (idx_q < CNT_W'(TABLE_ENTRIES)) && !stall;
	assign new_expiry = now_q + {16'd0, hold_seconds};
	assign wr_entry = '{family: fam_q, addr_high: hi_q, addr_low: lo_q, expiry: new_expiry};
	assign fin_go = (state_q == S_FIN) && out_free;
	assign alert_write = fin_go && (op_q == OP_ALERT) && !ignore_q && (match_q || free_q);
	assign push_s1 = hit && pend_vld_q && out_free;
	assign req_fam = (({req.version_nibble, 4'd0} & VERSION_MASK) != VERSION_V4);

	assign ram.re = issue;
	assign ram.raddr = idx_q[IDX_W-1:0];
	assign ram.we = alert_write;
	assign ram.waddr = match_q ? match_idx_q : free_idx_q;
	assign ram.wdata = wr_entry;

	always_comb begin
		fin_rsp = make_rsp(ACT_NOTHING, wr_entry, 32'd0, 1'b1);
		case (op_q)
			OP_ALERT: begin
				if (ignore_q) begin
					fin_rsp = make_rsp(ACT_IGNORED, wr_entry, 32'd0, 1'b1);
				end else if (match_q) begin
					fin_rsp = make_rsp(ACT_REFRESHED, wr_entry, 32'd0, 1'b1);
				end else if (free_q) begin
					fin_rsp = make_rsp(ACT_START, wr_entry, sig_q, 1'b1);
				end else begin
					fin_rsp = make_rsp(ACT_DROPPED, wr_entry, 32'd0, 1'b1);
				end
			end
			OP_TICK, OP_FLUSH: begin
				if (pend_vld_q) begin
					fin_rsp = pend_q;
					fin_rsp.last = 1'b1;
				end
			end
			default: begin
				fin_rsp = make_rsp(ACT_NOTHING, wr_entry, 32'd0, 1'b1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			now_q <= 32'd0;
			valid_q <= '0;
			idx_q <= '0;
			vld_s1 <= 1'b0;
			match_q <= 1'b0;
			free_q <= 1'b0;
			pend_vld_q <= 1'b0;
			cnt_q <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (req.opcode == OP_TICK) begin
							now_q <= now_q + 32'd1;
						end
						idx_q <= '0;
						vld_s1 <= 1'b0;
						match_q <= 1'b0;
						free_q <= 1'b0;
						pend_vld_q <= 1'b0;
						cnt_q <= '0;
						if (((req.opcode == OP_ALERT) && req.no_packet)
								|| (req.opcode == OP_NONE)) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (!stall) begin
						vld_s1 <= issue;
						idx_q <= idx_q + CNT_W'(issue);
						if (vld_s1) begin
							if (op_q == OP_ALERT) begin
								if (same) begin
									match_q <= 1'b1;
								end
								if (!ent_valid && !free_q) begin
									free_q <= 1'b1;
								end
							end
							if (hit) begin
								valid_q[idx_s1] <= 1'b0;
								pend_vld_q <= 1'b1;
								cnt_q <= cnt_q + RES_W'(1);
							end
						end
						if ((idx_q == CNT_W'(TABLE_ENTRIES)) && !vld_s1) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						if (alert_write && !match_q) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (push_s1 || fin_go) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req_valid) begin
			op_q <= req.opcode;
			ignore_q <= req.no_packet;
			fam_q <= req_fam;
			hi_q <= req_fam ? req.source_high : 64'd0;
			lo_q <= req_fam ? req.source_low : {32'd0, req.source_low[31:0]};
			sig_q <= req.signature_id;
		end
		if ((state_q == S_SCAN) && !stall) begin
			idx_s1 <= idx_q[IDX_W-1:0];
			if (vld_s1 && (op_q == OP_ALERT)) begin
				if (same) begin
					match_idx_q <= idx_s1;
				end
				if (!ent_valid && !free_q) begin
					free_idx_q <= idx_s1;
				end
			end
			if (hit) begin
				pend_q <= make_rsp(ACT_STOP, ram_rd_data, 32'd0, 1'b0);
			end
		end
		if (push_s1) begin
			rsp_q <= pend_q;
		end else if (fin_go) begin
			rsp_q <= fin_rsp;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_vld_q;
	assign rsp = rsp_q;

endmodule

>>> rtl/core/address_target_aging_table.sv
// Channel     Direction  Handshake                  Payload
// req         in         req_valid / req_ready      atat_pkg::req_t
// rsp         out        rsp_valid / rsp_ready      atat_pkg::rsp_t
// hold        in         hold_wr_en (no wait)       hold_wr_data, 16 bits
//
// An alert, tick or flush walks the entry memory one entry a cycle through its
// single read port, save where a tick or flush stalls, then ends in S_FIN; an
// ignored alert or an unused opcode goes from S_IDLE straight to S_FIN. A tick
// or flush stalls when a further result meets a pending one while rsp_ready low
// holds the output register. Reset clears the valid bits, the seconds counter
// and the hold time (60); entry contents are not cleared.
module address_target_aging_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           hold_wr_en,
	input  logic [15:0]    hold_wr_data,
	input  logic           req_valid,
	output logic           req_ready,
	input  atat_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output atat_pkg::rsp_t rsp
);
	import atat_pkg::*;

	logic [15:0] hold_q;
	ram_req_t    ram;
	entry_t      ram_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_RESET;
		end else if (hold_wr_en) begin
			hold_q <= hold_wr_data;
		end
	end

	atat_entry_ram u_ram (
		.clk     (clk),
		.ram     (ram),
		.rd_data (ram_rd_data)
	);

	atat_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.hold_seconds (hold_q),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp),
		.ram          (ram),
		.ram_rd_data  (ram_rd_data)
	);

endmodule
